### hdl/der_tlv_header_parser_macros.svh
// Assertion macros for the DER TLV header parser modules.
// No dependencies; included by each file that carries assertions.
`ifndef DER_TLV_HEADER_PARSER_MACROS_SVH
`define DER_TLV_HEADER_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTLV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTLV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dtlv_pkg.sv
// Package for the DER TLV header parser: beat types, phase and status codes,
// configuration register indexes and default parameter values. No dependencies.
package dtlv_pkg;

  localparam int DEF_OFFSET_WIDTH  = 32;
  localparam int DEF_MAX_LEN_BYTES = 4;

  localparam logic [7:0] LEN_LONG_FORM  = 8'h80;
  localparam logic [7:0] LEN_COUNT_MASK = 8'h7F;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REGION_LENGTH    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TAG_CHECK_ENABLE = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MATCH_TAG        = 2'd2;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_LEN     = 3'd1,
    PH_LONGLEN = 3'd2,
    PH_VALUE   = 3'd3,
    PH_HALT    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TRUNC_HEADER = 3'd1,
    ST_BAD_LEN_CNT  = 3'd2,
    ST_HDR_OVERRUN  = 3'd3,
    ST_VAL_OVERRUN  = 3'd4,
    ST_TAG_MISMATCH = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_start;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  elem_tag;
    logic [31:0] value_length;
    logic [31:0] value_offset;
  } result_t;

  typedef struct packed {
    logic [31:0] region_length;
    logic        tag_check_enable;
    logic [7:0]  match_tag;
  } cfg_t;

endpackage

### hdl/dtlv_core.sv
// Parse state and per-byte header decoding for the DER TLV header parser.
// Depends on dtlv_pkg and der_tlv_header_parser_macros.svh.
`include "der_tlv_header_parser_macros.svh"

module dtlv_core import dtlv_pkg::*; #(
  parameter int OFFSET_WIDTH  = DEF_OFFSET_WIDTH,
  parameter int MAX_LEN_BYTES = DEF_MAX_LEN_BYTES
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    res_valid,
  output result_t res
);

  localparam int LBW = $clog2(MAX_LEN_BYTES + 1);
  localparam int OW1 = OFFSET_WIDTH + 1;
  localparam logic [32:0] OffMax = 33'((64'd1 << OFFSET_WIDTH) - 64'd1);

  logic [OFFSET_WIDTH-1:0] byte_offset, byte_offset_next;
  phase_t                  phase, phase_next;
  logic [7:0]              held_tag, held_tag_next;
  logic [31:0]             length_accum, length_accum_next;
  logic [LBW-1:0]          length_bytes_left, length_bytes_left_next;
  logic [31:0]             value_bytes_left, value_bytes_left_next;

  logic [OFFSET_WIDTH-1:0] rlen;
  logic [OFFSET_WIDTH-1:0] cur_offset;
  phase_t                  cur_phase;
  logic [31:0]             cur_accum;
  logic [LBW-1:0]          cur_lb;
  logic [31:0]             cur_vb;
  logic [OFFSET_WIDTH-1:0] o1;
  logic [31:0]             acc_shift;
  logic [LBW-1:0]          lb_dec;
  logic [31:0]             vb_dec;
  logic [31:0]             fin_len;
  logic [32:0]             fin_sum;
  logic                    fin_over;
  logic [7:0]              cnt;
  logic [OW1-1:0]          hdr_sum;
  logic                    hdr_over;
  logic                    do_finish;

  // Effective region length, clamped so that the offset cannot wrap.
  assign rlen = ({1'b0, cfg.region_length} > OffMax) ? OffMax[OFFSET_WIDTH-1:0]
                                                     : cfg.region_length[OFFSET_WIDTH-1:0];

  // A region start clears the walk before the byte itself is parsed.
  assign cur_offset = item.region_start ? '0 : byte_offset;
  assign cur_phase  = item.region_start ? PH_TAG : phase;
  assign cur_accum  = item.region_start ? '0 : length_accum;
  assign cur_lb     = item.region_start ? '0 : length_bytes_left;
  assign cur_vb     = item.region_start ? '0 : value_bytes_left;

  assign o1        = cur_offset + OFFSET_WIDTH'(1);
  assign acc_shift = {cur_accum[23:0], item.data_byte};
  assign lb_dec    = (cur_lb != '0) ? cur_lb - LBW'(1) : '0;
  assign vb_dec    = (cur_vb != '0) ? cur_vb - 32'd1 : '0;
  assign fin_len   = (cur_phase == PH_LEN) ? 32'(item.data_byte) : acc_shift;
  assign fin_sum   = 33'(o1) + 33'(fin_len);
  assign fin_over  = fin_sum > 33'(rlen);
  assign cnt       = item.data_byte & LEN_COUNT_MASK;
  assign hdr_sum   = OW1'(o1) + OW1'(cnt);
  assign hdr_over  = hdr_sum > OW1'(rlen);

  always_comb begin
    byte_offset_next       = byte_offset;
    phase_next             = phase;
    held_tag_next          = held_tag;
    length_accum_next      = length_accum;
    length_bytes_left_next = length_bytes_left;
    value_bytes_left_next  = value_bytes_left;
    res_valid              = 1'b0;
    res.status             = ST_OK;
    res.elem_tag           = held_tag;
    res.value_length       = '0;
    res.value_offset       = '0;
    do_finish              = 1'b0;
    if (fire) begin
      byte_offset_next       = cur_offset;
      phase_next             = cur_phase;
      length_accum_next      = cur_accum;
      length_bytes_left_next = cur_lb;
      value_bytes_left_next  = cur_vb;
      if (cur_phase != PH_HALT && cur_offset < rlen) begin
        byte_offset_next = o1;
        case (cur_phase)
          PH_TAG: begin
            held_tag_next = item.data_byte;
            res.elem_tag  = item.data_byte;
            if (o1 >= rlen) begin
              res_valid  = 1'b1;
              res.status = ST_TRUNC_HEADER;
              phase_next = PH_HALT;
            end else begin
              phase_next = PH_LEN;
            end
          end
          PH_LEN: begin
            if ((item.data_byte & LEN_LONG_FORM) == '0) begin
              do_finish = 1'b1;
            end else if (cnt == '0 || cnt > 8'(MAX_LEN_BYTES)) begin
              res_valid  = 1'b1;
              res.status = ST_BAD_LEN_CNT;
              phase_next = PH_HALT;
            end else if (hdr_over) begin
              res_valid  = 1'b1;
              res.status = ST_HDR_OVERRUN;
              phase_next = PH_HALT;
            end else begin
              length_accum_next      = '0;
              length_bytes_left_next = cnt[LBW-1:0];
              phase_next             = PH_LONGLEN;
            end
          end
          PH_LONGLEN: begin
            length_accum_next      = acc_shift;
            length_bytes_left_next = lb_dec;
            if (lb_dec == '0) begin
              do_finish = 1'b1;
            end
          end
          PH_VALUE: begin
            value_bytes_left_next = vb_dec;
            if (vb_dec == '0) begin
              phase_next = PH_TAG;
            end
          end
          default: begin
            phase_next = PH_HALT;
          end
        endcase
        if (do_finish) begin
          res_valid        = 1'b1;
          res.value_length = fin_len;
          res.value_offset = 32'(o1);
          if (fin_over) begin
            res.status = ST_VAL_OVERRUN;
            phase_next = PH_HALT;
          end else if (cfg.tag_check_enable && held_tag != cfg.match_tag) begin
            res.status = ST_TAG_MISMATCH;
            phase_next = PH_HALT;
          end else begin
            value_bytes_left_next = fin_len;
            phase_next            = (fin_len == '0) ? PH_TAG : PH_VALUE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset       <= '0;
      phase             <= PH_TAG;
      held_tag          <= '0;
      length_accum      <= '0;
      length_bytes_left <= '0;
      value_bytes_left  <= '0;
    end else begin
      byte_offset       <= byte_offset_next;
      phase             <= phase_next;
      held_tag          <= held_tag_next;
      length_accum      <= length_accum_next;
      length_bytes_left <= length_bytes_left_next;
      value_bytes_left  <= value_bytes_left_next;
    end
  end

  `DTLV_ASSERT_NEXT(a_error_halts, clk, rst, res_valid && res.status != ST_OK, phase == PH_HALT, "error result did not halt parsing")
  `DTLV_ASSERT_NEXT(a_halt_holds, clk, rst, phase == PH_HALT && !(fire && item.region_start), phase == PH_HALT, "halt left without a region start")
  `DTLV_ASSERT_SAME(a_value_silent, clk, rst, fire && phase == PH_VALUE && !item.region_start, !res_valid, "value byte produced a result")

endmodule

### hdl/dtlv_out_buf.sv
// Two-entry result buffer that parts the parser from the result channel.
// Depends on dtlv_pkg.
module dtlv_out_buf import dtlv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    room,
  output logic    valid,
  output result_t data
);

  logic [1:0] count;
  result_t    slot0, slot1;

  assign room  = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign data  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry 0 is always the head; a pop moves entry 1 forward.
  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          slot0 <= push_data;
        end else begin
          slot1 <= push_data;
        end
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          slot0 <= push_data;
        end else begin
          slot0 <= slot1;
          slot1 <= push_data;
        end
      end
      default: begin
        slot0 <= slot0;
      end
    endcase
  end

endmodule

### hdl/der_tlv_header_parser.sv
// Top level of the DER TLV header parser: input beat register, configuration
// registers, parse core and result buffer. Depends on dtlv_pkg, dtlv_core and
// dtlv_out_buf.

// The parser takes one byte of a region per input beat and walks consecutive
// DER elements (tag byte, short or long-form length, value). For each element
// whose header completes it delivers one result beat with the tag, the value
// length and the region offset where the value begins; value bytes are skipped
// without results. Any error (truncated header, bad length count, header or
// value past the region end, or a tag that differs from the expected tag while
// checking is on) is reported in one result beat with a nonzero status, after
// which bytes are ignored until a beat with region_start set. Bytes beyond the
// region length are ignored silently. The block accepts one byte every cycle
// while the result buffer has a free entry: a byte waits in the input register
// while the core decodes it, and its result, if any, enters the result buffer
// as the byte is decoded and is offered on the result channel from then on.
// The result buffer holds two beats; ready on the input drops only while both
// are waiting and the input register is occupied. Configuration writes are
// taken in any cycle and should be made while no bytes are in flight.
module der_tlv_header_parser import dtlv_pkg::*; #(
  parameter int OFFSET_WIDTH  = DEF_OFFSET_WIDTH,
  parameter int MAX_LEN_BYTES = DEF_MAX_LEN_BYTES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  item_t                      item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output result_t                    result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [31:0]                cfg_data
);

  cfg_t    cfg;
  logic    stage_valid;
  item_t   stage_item;
  logic    buf_room;
  logic    proc_fire;
  logic    core_valid;
  result_t core_res;

  // Configuration writes never stall; an index beyond the register list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REGION_LENGTH:    cfg.region_length    <= cfg_data;
        CFG_TAG_CHECK_ENABLE: cfg.tag_check_enable <= cfg_data[0];
        CFG_MATCH_TAG:        cfg.match_tag        <= cfg_data[7:0];
        default:              cfg                  <= cfg;
      endcase
    end
  end

  // The held byte is decoded whenever the result buffer has a free entry, and
  // the input register refills in the same cycle.
  assign proc_fire  = stage_valid && buf_room;
  assign item_ready = !stage_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_item <= item;
    end
  end

  dtlv_core #(
    .OFFSET_WIDTH  (OFFSET_WIDTH),
    .MAX_LEN_BYTES (MAX_LEN_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (proc_fire),
    .item      (stage_item),
    .cfg       (cfg),
    .res_valid (core_valid),
    .res       (core_res)
  );

  dtlv_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (core_valid),
    .push_data (core_res),
    .pop       (result_valid && result_ready),
    .room      (buf_room),
    .valid     (result_valid),
    .data      (result)
  );

endmodule

### verif/tb_top.sv
// Self-checking testbench for der_tlv_header_parser: directed and random DER byte
// streams with a built-in header predictor and an in-order result check.
// Depends on dtlv_pkg and the der_tlv_header_parser RTL only.
`timescale 1ns / 100ps

module tb_top;
  import dtlv_pkg::*;

  // Settling time that lets bytes which produce no result but are still in
  // flight leave the pipeline.
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_BEATS  = 1250;
  // Over 25 times the slowest plausible run at full stall rates.
  localparam longint TIMEOUT_NS = 10_000_000;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       item_valid;
  logic                       item_ready;
  item_t                      item;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  result_t                    result;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [31:0]                cfg_data;

  der_tlv_header_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Copies of the configuration registers, updated as each write beat lands.
  logic [31:0] reg_region_len = '0;
  logic        reg_tag_check  = 1'b0;
  logic [7:0]  reg_match_tag  = '0;

  // Parser state as the predictor sees it. Reset counts as a region start, so
  // these start out exactly as a fresh region would.
  longint unsigned hdr_offset    = 0;
  phase_t          hdr_phase     = PH_TAG;
  logic [7:0]      hdr_tag       = '0;
  logic [31:0]     hdr_len_acc   = '0;
  logic [2:0]      hdr_len_left  = '0;
  logic [31:0]     hdr_skip_left = '0;

  // Predicted result beats, oldest first.
  result_t pending_headers[$];

  // Bytes of the region currently being generated by the random test.
  logic [7:0] region_bytes[$];

  bit gaps_on = 1'b1;
  int fail_count      = 0;
  int beats_sent      = 0;
  int results_checked = 0;
  int regions_sent    = 0;
  int configs_written = 0;
  int status_seen[8];

  // Fill in one result beat. Any nonzero status halts the parser until the
  // next region start.
  function automatic bit post_result(input status_t st, input logic [31:0] len,
                                     input longint unsigned start, output result_t hdr);
    hdr.status       = st;
    hdr.elem_tag     = hdr_tag;
    hdr.value_length = len;
    hdr.value_offset = start[31:0];
    if (st != ST_OK) hdr_phase = PH_HALT;
    return 1'b1;
  endfunction

  // The header is complete: range check first, then the tag check, and only
  // then does the parser move on to skipping the value.
  function automatic bit close_header(input longint unsigned start, input logic [31:0] len,
                                      output result_t hdr);
    if (start + len > reg_region_len) return post_result(ST_VAL_OVERRUN, len, start, hdr);
    if (reg_tag_check && hdr_tag != reg_match_tag) begin
      return post_result(ST_TAG_MISMATCH, len, start, hdr);
    end
    hdr_skip_left = len;
    hdr_phase     = (len == 0) ? PH_TAG : PH_VALUE;
    return post_result(ST_OK, len, start, hdr);
  endfunction

  // Advance the predicted parser by one accepted byte. Returns 1 when the byte
  // produces a result beat, which is then left in hdr.
  function automatic bit decode_byte(input item_t beat, output result_t hdr);
    longint unsigned pos;
    logic [7:0]      b;
    int unsigned     cnt;
    hdr = '0;
    b   = beat.data_byte;
    if (beat.region_start) begin
      hdr_offset    = 0;
      hdr_phase     = PH_TAG;
      hdr_len_acc   = '0;
      hdr_len_left  = '0;
      hdr_skip_left = '0;
    end
    // Halted, or beyond the end of the region: the byte leaves no trace.
    if (hdr_phase == PH_HALT || hdr_offset >= reg_region_len) return 1'b0;
    pos        = hdr_offset;
    hdr_offset = pos + 1;
    case (hdr_phase)
      PH_TAG: begin
        hdr_tag = b;
        // A tag on the last byte of the region can never get its length.
        if (pos + 1 >= reg_region_len) return post_result(ST_TRUNC_HEADER, '0, 0, hdr);
        hdr_phase = PH_LEN;
      end
      PH_LEN: begin
        if ((b & LEN_LONG_FORM) == 8'h00) return close_header(pos + 1, {24'd0, b}, hdr);
        cnt = b & LEN_COUNT_MASK;
        if (cnt == 0 || cnt > DEF_MAX_LEN_BYTES) return post_result(ST_BAD_LEN_CNT, '0, 0, hdr);
        if (pos + 1 + cnt > reg_region_len) return post_result(ST_HDR_OVERRUN, '0, 0, hdr);
        hdr_len_acc  = '0;
        hdr_len_left = 3'(cnt);
        hdr_phase    = PH_LONGLEN;
      end
      PH_LONGLEN: begin
        hdr_len_acc = {hdr_len_acc[23:0], b};
        if (hdr_len_left != 0) hdr_len_left = hdr_len_left - 3'd1;
        if (hdr_len_left == 0) return close_header(pos + 1, hdr_len_acc, hdr);
      end
      PH_VALUE: begin
        if (hdr_skip_left != 0) hdr_skip_left = hdr_skip_left - 32'd1;
        if (hdr_skip_left == 0) hdr_phase = PH_TAG;
      end
      default: begin
        hdr_phase = PH_HALT;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      fail_count++;
    end
  endfunction

  // The receiver stalls at random, about 28 percent of the time, while gaps are on.
  always @(posedge clk) begin
    result_ready <= !gaps_on || ($urandom_range(99) >= 28);
  end

  // One process watches both channels. A byte beat is predicted before the
  // result beat of the same edge is checked, so the order of the two never
  // matters even if the block were faster than expected.
  always @(posedge clk) begin : watch
    result_t predicted, want, got;
    if (!rst) begin
      if (item_valid && item_ready) begin
        if (decode_byte(item, predicted)) pending_headers.push_back(predicted);
      end
      if (result_valid && result_ready) begin
        got = result;
        results_checked++;
        status_seen[got.status]++;
        if (pending_headers.size() == 0) begin
          $display("%0t: result beat with none expected, actual status %0d tag 0x%0h len 0x%0h off 0x%0h",
                   $time, got.status, got.elem_tag, got.value_length, got.value_offset);
          fail_count++;
        end else begin
          want = pending_headers.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("elem_tag", 32'(want.elem_tag), 32'(got.elem_tag));
          check_field("value_length", want.value_length, got.value_length);
          check_field("value_offset", want.value_offset, got.value_offset);
        end
      end
    end
  end

  // Offer one byte beat and hold it until the block takes it. While gaps are on
  // the sender goes quiet for a random number of cycles first.
  task automatic send_byte(input logic [7:0] b, input bit rs);
    if (gaps_on) begin
      while ($urandom_range(99) < 28) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item       <= '{data_byte: b, region_start: rs};
    do @(posedge clk); while (!item_ready);
    beats_sent++;
  endtask

  // Stop sending and wait until every predicted result has been delivered,
  // then let the last bytes without results leave the pipeline.
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One write beat; cfg_valid is left as the caller set it.
  task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_REGION_LENGTH:    reg_region_len = data;
      CFG_TAG_CHECK_ENABLE: reg_tag_check  = data[0];
      CFG_MATCH_TAG:        reg_match_tag  = data[7:0];
      default: ;
    endcase
  endtask

  // Registers are only ever written with the block idle.
  task automatic write_regs(input logic [31:0] rl, input logic tce, input logic [7:0] etag);
    settle();
    cfg_valid <= 1'b1;
    cfg_write(CFG_REGION_LENGTH, rl);
    cfg_write(CFG_TAG_CHECK_ENABLE, {31'd0, tce});
    cfg_write(CFG_MATCH_TAG, {24'd0, etag});
    cfg_valid <= 1'b0;
    configs_written++;
  endtask

  // No region start after reset: a null element, then a long-form length that
  // would run past the end of a four-byte region, then a byte while halted.
  task automatic test_reset_as_region_start();
    write_regs(32'd4, 1'b0, 8'h00);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h84, 1'b0);
    send_byte(8'h55, 1'b0);
  endtask

  // A three-byte region gives a bad length count twice, a truncated header and a
  // value overrun in turn, then a byte that falls past the end of the region.
  task automatic test_length_errors();
    write_regs(32'd3, 1'b0, 8'hFF);
    // long form with a zero count
    send_byte(8'h02, 1'b1);
    send_byte(8'h80, 1'b0);
    // long form with a count above four
    send_byte(8'h02, 1'b1);
    send_byte(8'h85, 1'b0);
    // empty element, then a tag on the final byte
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h07, 1'b0);
    // value that would overrun the region
    send_byte(8'h04, 1'b1);
    send_byte(8'h05, 1'b0);
    // one-byte value that exactly fills the region, then a stray byte
    send_byte(8'h06, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hBB, 1'b0);
  endtask

  // Largest region with tag checking on: a four-byte long-form length on a
  // matching tag, then an element whose tag does not match.
  task automatic test_tag_check();
    write_regs(32'hFFFF_FFFF, 1'b1, 8'hFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h84, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h30, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // A region of length zero swallows everything silently.
  task automatic test_empty_region();
    write_regs(32'd0, 1'b0, 8'h00);
    send_byte(8'hFF, 1'b1);
  endtask

  // Build one region's bytes. Most regions are chains of well-formed elements
  // with random tags, lengths and content, sized to roughly fill a region of up to 64
  // bytes, with the odd broken length or oversized value mixed in; the rest is noise.
  task automatic build_region();
    int unsigned target, room, len, form, cnt;
    logic [7:0]  tag;
    region_bytes.delete();
    if (reg_region_len <= 64) target = reg_region_len + $urandom_range(0, 3);
    else target = $urandom_range(8, 48);
    if ($urandom_range(99) < 12) begin
      repeat (target) region_bytes.push_back(8'($urandom_range(255)));
    end else begin
      while (region_bytes.size() < target) begin
        if (reg_tag_check && $urandom_range(3) != 0) tag = reg_match_tag;
        else tag = 8'($urandom_range(255));
        room = (target > region_bytes.size() + 2) ? target - region_bytes.size() - 2 : 0;
        len  = ($urandom_range(7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, room);
        form = $urandom_range(9);
        region_bytes.push_back(tag);
        if (form < 6 && len < 128) begin
          region_bytes.push_back(8'(len));
        end else if (form < 9) begin
          cnt = $urandom_range(1, DEF_MAX_LEN_BYTES);
          if ($urandom_range(5) == 0) len = $urandom();
          region_bytes.push_back(LEN_LONG_FORM | 8'(cnt));
          for (int i = int'(cnt) - 1; i >= 0; i--) region_bytes.push_back(8'(len >> (8 * i)));
        end else begin
          // broken length count: zero or more than four bytes
          region_bytes.push_back($urandom_range(1) ? LEN_LONG_FORM : 8'($urandom_range(8'h85, 8'hFF)));
        end
        for (int unsigned i = 0; i < len && region_bytes.size() < target; i++) begin
          region_bytes.push_back(8'($urandom_range(255)));
        end
      end
    end
  endtask

  // Random regions under changing settings. The first stretch runs with no
  // idling on either side; after that both sides stall at random.
  task automatic test_random_regions();
    int          beats;
    logic [31:0] rl;
    logic [7:0]  etag;
    beats   = 0;
    gaps_on = 1'b0;
    while (beats < RANDOM_BEATS) begin
      if (beats > 250) gaps_on = 1'b1;
      if (regions_sent % 4 == 0 || $urandom_range(5) == 0) begin
        case ($urandom_range(9))
          0: rl = 32'd0;
          1: rl = 32'd1;
          2: rl = 32'd2;
          3: rl = 32'hFFFF_FFFF;
          4: rl = $urandom();
          default: rl = $urandom_range(3, 48);
        endcase
        case ($urandom_range(3))
          0: etag = 8'h00;
          1: etag = 8'hFF;
          default: etag = 8'($urandom_range(255));
        endcase
        write_regs(rl, 1'($urandom_range(1)), etag);
      end else if ($urandom_range(7) == 0) begin
        // Hold the sender back until the result side has caught up.
        settle();
      end
      build_region();
      // Mostly the first byte opens the region; occasionally it does not, and
      // now and then a region start lands in the middle.
      foreach (region_bytes[i]) begin
        send_byte(region_bytes[i], (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(99) == 0));
      end
      beats += region_bytes.size();
      regions_sent++;
    end
  endtask

  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_REGION_LENGTH;
    cfg_data   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_as_region_start();
    test_length_errors();
    test_tag_check();
    test_empty_region();
    test_random_regions();
    settle();

    $display("Run covered %0d byte beats in %0d random regions under %0d register settings, %0d result beats checked.",
             beats_sent, regions_sent, configs_written, results_checked);
    $display("Error beats seen: truncated %0d, bad count %0d, header overrun %0d, value overrun %0d, tag mismatch %0d.",
             status_seen[ST_TRUNC_HEADER], status_seen[ST_BAD_LEN_CNT], status_seen[ST_HDR_OVERRUN],
             status_seen[ST_VAL_OVERRUN], status_seen[ST_TAG_MISMATCH]);
    if (fail_count == 0) begin
      $display("der_tlv_header_parser regression: pass");
    end else begin
      $display("der_tlv_header_parser regression: fail");
    end
    $finish;
  end

  // Watchdog: a stuck handshake or a result that never arrives ends here.
  initial begin
    #(TIMEOUT_NS);
    $display("der_tlv_header_parser regression: fail");
    $finish;
  end

endmodule
